// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Field widths, codes, state encoding and shared structures.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int DEF_NUM_BLOCKS = 1024;
    localparam int DEF_NUM_JOBS   = 16;
    localparam int DEF_MAX_PAGES  = 64;

    localparam int WORD_IDX_W = 4;
    localparam int WORD_BITS  = 1 << WORD_IDX_W;

    localparam int KIND_W        = 1;
    localparam int JOB_W         = 4;
    localparam int PAGE_CNT_W    = 7;
    localparam int STATUS_W      = 2;
    localparam int PAGE_IDX_W    = 6;
    localparam int BLOCK_NUM_W   = 10;
    localparam int REL_CNT_W     = 7;
    localparam int FREE_CNT_W    = 11;
    localparam int BLOCK_COUNT_W = 11;

    localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NO_PAGES = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_AL_RD,
        S_AL_LD,
        S_AL_SCAN,
        S_RL_PT,
        S_RL_BM,
        S_RL_WR,
        S_RL_FIN
    } t_state;

    typedef struct packed {
        t_status                 status;
        logic [PAGE_IDX_W-1:0]   page_index;
        logic [BLOCK_NUM_W-1:0]  block_number;
        logic [REL_CNT_W-1:0]    released_count;
        logic [FREE_CNT_W-1:0]   free_count;
        logic                    last;
    } t_rsp;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_bm_ctl;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_pt_ctl;

endpackage

`default_nettype wire

// ----- src/bpa_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or release request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [JOB_W-1:0]      job_id;
    logic [PAGE_CNT_W-1:0] page_count;

    modport source (output valid, output kind, output job_id, output page_count,
                    input ready);
    modport sink   (input valid, input kind, input job_id, input page_count,
                    output ready);

endinterface

`default_nettype wire

// ----- src/bpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_rsp_if import bpa_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [PAGE_IDX_W-1:0]  page_index;
    logic [BLOCK_NUM_W-1:0] block_number;
    logic [REL_CNT_W-1:0]   released_count;
    logic [FREE_CNT_W-1:0]  free_count;
    logic                   last;

    modport source (output valid, output status, output page_index, output block_number,
                    output released_count, output free_count, output last,
                    input ready);
    modport sink   (input valid, input status, input page_index, input block_number,
                    input released_count, input free_count, input last,
                    output ready);

endinterface

`default_nettype wire

// ----- src/bpa_bitmap.sv -----
// ----------------------------------------------------------------------------
// Block bitmap memory
// Used/free bits in words, one synchronous read and one write port,
// with a valid flag per word so that a clear takes effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_bitmap import bpa_pkg::*; #(
    parameter int WORDS = DEF_NUM_BLOCKS / WORD_BITS,
    parameter int AW    = $clog2(DEF_NUM_BLOCKS / WORD_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_bm_ctl              i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten words read as all free
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- src/bpa_page_table.sv -----
// ----------------------------------------------------------------------------
// Job page table memory
// Block number per job page, one synchronous read and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_page_table import bpa_pkg::*; #(
    parameter int DEPTH = DEF_NUM_JOBS * DEF_MAX_PAGES,
    parameter int AW    = $clog2(DEF_NUM_JOBS * DEF_MAX_PAGES),
    parameter int DW    = $clog2(DEF_NUM_BLOCKS)
) (
    input  logic          i_clk,
    input  t_pt_ctl       i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/bpa_out_stage.sv -----
// ----------------------------------------------------------------------------
// Result output register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_out_stage import bpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_rsp      i_data,
    output logic      o_can_load,
    bpa_rsp_if.source o_rsp
);

    logic r_valid;
    t_rsp r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_can_load           = !r_valid || o_rsp.ready;
    assign o_rsp.valid          = r_valid;
    assign o_rsp.status         = r_data.status;
    assign o_rsp.page_index     = r_data.page_index;
    assign o_rsp.block_number   = r_data.block_number;
    assign o_rsp.released_count = r_data.released_count;
    assign o_rsp.free_count     = r_data.free_count;
    assign o_rsp.last           = r_data.last;

endmodule

`default_nettype wire

// ----- src/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Used/free bitmap over the memory blocks, free count and per-job page tables.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the result register lets the next request
// in while the last result waits. A held-off result sink stalls the allocator.
// A failing or empty request passes through the emit state to the result
// register. An allocate reads the bitmap a 16-bit word at a time, takes the
// free blocks of each word that lie below the block count, and sends one page
// per cycle within a word while the result sink takes them. A release reads
// each held page from the page table and clears its bit in the bitmap with a
// read-modify-write. Reset and a block_count write clear the bitmap at once
// through per-word valid flags; there is no clearing pass. Write block_count
// only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int NUM_JOBS   = DEF_NUM_JOBS,
    parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [BLOCK_COUNT_W-1:0] i_cfg_wdata,
    bpa_req_if.sink                  i_req,
    bpa_rsp_if.source                o_rsp
);

    localparam int WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BNW   = AW + WORD_IDX_W;
    localparam int CW    = $clog2(NUM_BLOCKS + 1);
    localparam int XW    = (CW > BLOCK_COUNT_W) ? CW : BLOCK_COUNT_W;
    localparam int JAW   = $clog2(NUM_JOBS);
    localparam int PAW   = $clog2(MAX_PAGES);
    localparam int PCW   = $clog2(MAX_PAGES + 1);
    localparam int PT_AW = JAW + PAW;
    localparam int PT_DEPTH = NUM_JOBS * (1 << PAW);
    localparam int RST_FREE = (int'(BLOCK_COUNT_RESET) > NUM_BLOCKS) ?
                              NUM_BLOCKS : int'(BLOCK_COUNT_RESET);

    t_state                   r_state, n_state;
    logic [BLOCK_COUNT_W-1:0] r_block_count, n_block_count;
    logic [CW-1:0]            r_free, n_free;
    logic [PCW-1:0]           r_total [NUM_JOBS];
    logic [PCW-1:0]           n_total [NUM_JOBS];
    logic [JAW-1:0]           r_job, n_job;
    logic [PCW-1:0]           r_want, n_want;
    logic [PCW-1:0]           r_k, n_k;
    logic [AW-1:0]            r_waddr, n_waddr;
    logic [WORD_BITS-1:0]     r_word, n_word;
    logic [BNW-1:0]           r_blk, n_blk;
    t_rsp                     r_res, n_res;

    logic [CW-1:0]            w_eff;
    logic [CW-1:0]            w_cfg_eff;
    logic                     w_accept;
    logic                     w_job_ok;
    logic [JAW-1:0]           w_job_idx;
    logic [PCW-1:0]           w_job_total;
    logic [WORD_BITS-1:0]     w_lim;
    logic [WORD_BITS-1:0]     w_avail;
    logic                     w_hit;
    logic [WORD_IDX_W-1:0]    w_bit;
    logic [WORD_BITS-1:0]     w_onehot;
    logic [PCW-1:0]           w_k_inc;
    logic [CW:0]              w_rel_sum;

    t_bm_ctl                  w_bm_ctl;
    logic [AW-1:0]            w_bm_rd_addr;
    logic [AW-1:0]            w_bm_wr_addr;
    logic [WORD_BITS-1:0]     w_bm_wr_data;
    logic [WORD_BITS-1:0]     w_bm_rd_data;
    t_pt_ctl                  w_pt_ctl;
    logic [PT_AW-1:0]         w_pt_rd_addr;
    logic [PT_AW-1:0]         w_pt_wr_addr;
    logic [BNW-1:0]           w_pt_wr_data;
    logic [BNW-1:0]           w_pt_rd_data;
    logic                     w_out_load;
    logic                     w_out_can_load;
    t_rsp                     w_out_data;

    bpa_bitmap #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_bm_ctl),
        .i_rd_addr (w_bm_rd_addr),
        .i_wr_addr (w_bm_wr_addr),
        .i_wr_data (w_bm_wr_data),
        .o_rd_data (w_bm_rd_data)
    );

    bpa_page_table #(
        .DEPTH (PT_DEPTH),
        .AW    (PT_AW),
        .DW    (BNW)
    ) u_page_table (
        .i_clk     (i_clk),
        .i_ctl     (w_pt_ctl),
        .i_rd_addr (w_pt_rd_addr),
        .i_wr_addr (w_pt_wr_addr),
        .i_wr_data (w_pt_wr_data),
        .o_rd_data (w_pt_rd_data)
    );

    bpa_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_out_load),
        .i_data     (w_out_data),
        .o_can_load (w_out_can_load),
        .o_rsp      (o_rsp)
    );

    assign w_eff = (XW'(r_block_count) > XW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                          : CW'(r_block_count);
    assign w_cfg_eff = (XW'(i_cfg_wdata) > XW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                            : CW'(i_cfg_wdata);

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_job_ok    = int'(i_req.job_id) < NUM_JOBS;
    assign w_job_idx   = JAW'(i_req.job_id);
    assign w_job_total = w_job_ok ? r_total[w_job_idx] : '0;
    assign w_k_inc     = PCW'(r_k + 1'b1);
    assign w_rel_sum   = {1'b0, r_free} + (CW + 1)'(r_want);

    // lowest free block of the held word that lies below the block count
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_lim[j] = int'({r_waddr, WORD_IDX_W'(j)}) < int'(w_eff);
        end
        w_avail = ~r_word & w_lim;
        w_hit   = |w_avail;
        w_bit   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                w_bit = WORD_IDX_W'(j);
            end
        end
        w_onehot = WORD_BITS'(1) << w_bit;
    end

    always_comb begin
        n_state       = r_state;
        n_block_count = r_block_count;
        n_free        = r_free;
        n_total       = r_total;
        n_job         = r_job;
        n_want        = r_want;
        n_k           = r_k;
        n_waddr       = r_waddr;
        n_word        = r_word;
        n_blk         = r_blk;
        n_res         = r_res;

        w_bm_ctl      = '0;
        w_bm_rd_addr  = r_waddr;
        w_bm_wr_addr  = r_waddr;
        w_bm_wr_data  = r_word;
        w_pt_ctl      = '0;
        w_pt_rd_addr  = {r_job, r_k[PAW-1:0]};
        w_pt_wr_addr  = {r_job, r_k[PAW-1:0]};
        w_pt_wr_data  = {r_waddr, w_bit};
        w_out_load    = 1'b0;
        w_out_data    = r_res;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_job                = w_job_idx;
                    n_want               = PCW'(i_req.page_count);
                    n_k                  = '0;
                    n_waddr              = '0;
                    n_res.status         = ST_OK;
                    n_res.page_index     = '0;
                    n_res.block_number   = '0;
                    n_res.released_count = '0;
                    n_res.free_count     = FREE_CNT_W'(r_free);
                    n_res.last           = 1'b1;
                    n_state              = S_EMIT;
                    if (i_req.kind == KIND_ALLOC) begin
                        if (!w_job_ok || w_job_total != '0) begin
                            n_res.status = ST_BUSY;
                        end else if (int'(i_req.page_count) > MAX_PAGES ||
                                     int'(i_req.page_count) > int'(r_free)) begin
                            n_res.status = ST_NO_SPACE;
                        end else if (i_req.page_count != '0) begin
                            n_free  = r_free - CW'(i_req.page_count);
                            n_state = S_AL_RD;
                        end
                    end else begin
                        if (!w_job_ok || w_job_total == '0) begin
                            n_res.status = ST_NO_PAGES;
                        end else begin
                            n_want  = w_job_total;
                            n_state = S_RL_PT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_out_can_load) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_AL_RD: begin
                w_bm_ctl.rd_en = 1'b1;
                n_state        = S_AL_LD;
            end
            S_AL_LD: begin
                n_word  = w_bm_rd_data;
                n_state = S_AL_SCAN;
            end
            S_AL_SCAN: begin
                if (w_hit) begin
                    if (w_out_can_load) begin
                        w_out_load                = 1'b1;
                        w_out_data.status         = ST_OK;
                        w_out_data.page_index     = PAGE_IDX_W'(r_k);
                        w_out_data.block_number   = BLOCK_NUM_W'({r_waddr, w_bit});
                        w_out_data.released_count = '0;
                        w_out_data.free_count     = FREE_CNT_W'(r_free);
                        w_out_data.last           = (w_k_inc == r_want);
                        w_pt_ctl.wr_en            = 1'b1;
                        n_word                    = r_word | w_onehot;
                        n_k                       = w_k_inc;
                        if (w_k_inc == r_want) begin
                            w_bm_ctl.wr_en = 1'b1;
                            w_bm_wr_data   = r_word | w_onehot;
                            n_total[r_job] = r_want;
                            n_state        = S_IDLE;
                        end
                    end
                end else begin
                    // write back the exhausted word, fetch the next
                    w_bm_ctl.wr_en = 1'b1;
                    w_bm_ctl.rd_en = 1'b1;
                    w_bm_rd_addr   = AW'(r_waddr + 1'b1);
                    n_waddr        = AW'(r_waddr + 1'b1);
                    n_state        = S_AL_LD;
                end
            end
            S_RL_PT: begin
                w_pt_ctl.rd_en = 1'b1;
                n_state        = S_RL_BM;
            end
            S_RL_BM: begin
                n_blk          = w_pt_rd_data;
                w_bm_ctl.rd_en = 1'b1;
                w_bm_rd_addr   = w_pt_rd_data[BNW-1:WORD_IDX_W];
                n_state        = S_RL_WR;
            end
            S_RL_WR: begin
                w_bm_ctl.wr_en = 1'b1;
                w_bm_wr_addr   = r_blk[BNW-1:WORD_IDX_W];
                w_bm_wr_data   = w_bm_rd_data &
                                 ~(WORD_BITS'(1) << r_blk[WORD_IDX_W-1:0]);
                n_k            = w_k_inc;
                if (w_k_inc == r_want) begin
                    n_state = S_RL_FIN;
                end else begin
                    w_pt_ctl.rd_en = 1'b1;
                    w_pt_rd_addr   = {r_job, w_k_inc[PAW-1:0]};
                    n_state        = S_RL_BM;
                end
            end
            S_RL_FIN: begin
                n_free               = (w_rel_sum > (CW + 1)'(w_eff)) ? w_eff
                                                                      : CW'(w_rel_sum);
                n_total[r_job]       = '0;
                n_res.status         = ST_OK;
                n_res.page_index     = '0;
                n_res.block_number   = '0;
                n_res.released_count = REL_CNT_W'(r_want);
                n_res.free_count     = FREE_CNT_W'(n_free);
                n_res.last           = 1'b1;
                n_state              = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // reset the bitmap, free count and job page totals on a block count write
        if (i_cfg_we) begin
            n_block_count  = i_cfg_wdata;
            n_free         = w_cfg_eff;
            w_bm_ctl.clear = 1'b1;
            for (int j = 0; j < NUM_JOBS; j++) begin
                n_total[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= BLOCK_COUNT_RESET;
            r_free        <= CW'(RST_FREE);
            for (int j = 0; j < NUM_JOBS; j++) begin
                r_total[j] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_block_count <= n_block_count;
            r_free        <= n_free;
            r_total       <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_want  <= n_want;
        r_k     <= n_k;
        r_waddr <= n_waddr;
        r_word  <= n_word;
        r_blk   <= n_blk;
        r_res   <= n_res;
    end

    `ASSERT_IMPLY(a_free_in_range, i_clk, i_rst_n, 1'b1, r_free <= w_eff)
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_out_load, o_rsp.valid)
    `ASSERT_IMPLY(a_page_is_ok, i_clk, i_rst_n,
                  o_rsp.valid && (o_rsp.page_index != '0), o_rsp.status == ST_OK)

endmodule

`default_nettype wire

// ----- bench/bpa_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap page allocator result checker
// Watches the request, result and block_count channels, keeps its own copy of
// the bitmap, free count and page tables, predicts every result of each
// accepted request and compares the results in order, field by field.
// ----------------------------------------------------------------------------

module bpa_result_checker import bpa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [BLOCK_COUNT_W-1:0] i_cfg_wdata,
    bpa_req_if                       i_req,
    bpa_rsp_if                       i_rsp,
    output int                       o_fail_count,
    output int                       o_pending
);

    logic [BLOCK_COUNT_W-1:0] blocks_in_use;
    bit                       block_taken [DEF_NUM_BLOCKS];
    logic [FREE_CNT_W-1:0]    free_left;
    logic [BLOCK_NUM_W-1:0]   page_table [DEF_NUM_JOBS][DEF_MAX_PAGES];
    logic [PAGE_CNT_W-1:0]    pages_held [DEF_NUM_JOBS];
    t_rsp                     awaited_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int effective_blocks();
        return (blocks_in_use > DEF_NUM_BLOCKS) ? DEF_NUM_BLOCKS : int'(blocks_in_use);
    endfunction

    task automatic start_over();
        for (int b = 0; b < DEF_NUM_BLOCKS; b++) block_taken[b] = 1'b0;
        for (int j = 0; j < DEF_NUM_JOBS; j++) pages_held[j] = '0;
        free_left = FREE_CNT_W'(effective_blocks());
    endtask

    task automatic queue_result(input t_status status, input int page, input int block,
                                input int released, input bit last);
        t_rsp r;
        r.status         = status;
        r.page_index     = PAGE_IDX_W'(page);
        r.block_number   = BLOCK_NUM_W'(block);
        r.released_count = REL_CNT_W'(released);
        r.free_count     = free_left;
        r.last           = last;
        awaited_results.push_back(r);
    endtask

    task automatic predict_request(input logic [KIND_W-1:0] kind,
                                   input logic [JOB_W-1:0] job,
                                   input logic [PAGE_CNT_W-1:0] want);
        int n;
        int k;
        int f;
        n = effective_blocks();
        k = 0;
        if (kind == KIND_ALLOC) begin
            if (pages_held[job] != 0) begin
                queue_result(ST_BUSY, 0, 0, 0, 1'b1);
            end else if (want > DEF_MAX_PAGES || want > free_left) begin
                queue_result(ST_NO_SPACE, 0, 0, 0, 1'b1);
            end else if (want == 0) begin
                queue_result(ST_OK, 0, 0, 0, 1'b1);
            end else begin
                for (int b = 0; b < n && k < want; b++)
                    if (!block_taken[b]) k++;
                if (k < want) begin
                    queue_result(ST_NO_SPACE, 0, 0, 0, 1'b1);
                end else begin
                    free_left = free_left - want;
                    k = 0;
                    for (int b = 0; b < n && k < want; b++) begin
                        if (!block_taken[b]) begin
                            block_taken[b] = 1'b1;
                            page_table[job][k] = BLOCK_NUM_W'(b);
                            queue_result(ST_OK, k, b, 0, (k + 1) == want);
                            k++;
                        end
                    end
                    pages_held[job] = want;
                end
            end
        end else begin
            if (pages_held[job] == 0) begin
                queue_result(ST_NO_PAGES, 0, 0, 0, 1'b1);
            end else begin
                for (int i = 0; i < pages_held[job] && i < DEF_MAX_PAGES; i++)
                    block_taken[page_table[job][i]] = 1'b0;
                f = int'(free_left) + int'(pages_held[job]);
                if (f > n) f = n;
                free_left = FREE_CNT_W'(f);
                queue_result(ST_OK, 0, 0, pages_held[job], 1'b1);
                pages_held[job] = '0;
            end
        end
    endtask

    task automatic check_result();
        t_rsp exp;
        if (awaited_results.size() == 0) begin
            $error("result transaction with no request outstanding");
            o_fail_count++;
        end else begin
            exp = awaited_results.pop_front();
            if (i_rsp.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, i_rsp.status);
                o_fail_count++;
            end
            if (i_rsp.page_index !== exp.page_index) begin
                $error("page_index: expected %0d, actual %0d", exp.page_index,
                       i_rsp.page_index);
                o_fail_count++;
            end
            if (i_rsp.block_number !== exp.block_number) begin
                $error("block_number: expected %0d, actual %0d", exp.block_number,
                       i_rsp.block_number);
                o_fail_count++;
            end
            if (i_rsp.released_count !== exp.released_count) begin
                $error("released_count: expected %0d, actual %0d", exp.released_count,
                       i_rsp.released_count);
                o_fail_count++;
            end
            if (i_rsp.free_count !== exp.free_count) begin
                $error("free_count: expected %0d, actual %0d", exp.free_count,
                       i_rsp.free_count);
                o_fail_count++;
            end
            if (i_rsp.last !== exp.last) begin
                $error("last: expected %0d, actual %0d", exp.last, i_rsp.last);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blocks_in_use = BLOCK_COUNT_RESET;
            start_over();
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                blocks_in_use = i_cfg_wdata;
                start_over();
            end
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) check_result();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                predict_request(i_req.kind, i_req.job_id, i_req.page_count);
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- bench/tb_bitmap_page_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives directed and random allocate and release requests under several
// block counts and idling patterns, with a long result stall, and reports the
// verdict from the checker's failure count and pending results.
// ----------------------------------------------------------------------------

module tb_bitmap_page_allocator import bpa_pkg::*; ();

    localparam int CYCLE_LIMIT    = 500000;
    localparam int RX_HOLD_CYCLES = 400;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [BLOCK_COUNT_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    bit job_holds [DEF_NUM_JOBS];

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    bitmap_page_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    bpa_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen    <= hold_trigger;
            hold_left    <= RX_HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [JOB_W-1:0] job,
                                input logic [PAGE_CNT_W-1:0] pages);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.job_id     <= job;
        req_ch.page_count <= pages;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_block_count(input logic [BLOCK_COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        for (int j = 0; j < DEF_NUM_JOBS; j++) job_holds[j] = 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly allocate to free jobs and release held ones; the rest is broken order.
    task automatic run_random(input int count);
        logic [KIND_W-1:0]     kind;
        logic [JOB_W-1:0]      job;
        logic [PAGE_CNT_W-1:0] pages;
        int                    roll;
        for (int i = 0; i < count; i++) begin
            job  = JOB_W'($urandom_range(DEF_NUM_JOBS - 1));
            kind = job_holds[job] ? KIND_RELEASE : KIND_ALLOC;
            if ($urandom_range(99) < 15) kind = ~kind;
            roll = $urandom_range(99);
            if (roll < 70)
                pages = PAGE_CNT_W'($urandom_range(16, 1));
            else if (roll < 90)
                pages = PAGE_CNT_W'($urandom_range(64, 17));
            else if (roll < 94)
                pages = '0;
            else
                pages = PAGE_CNT_W'($urandom_range(127, 65));
            send_request(kind, job, pages);
            job_holds[job] = (kind == KIND_ALLOC) && (pages != 0);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_ALLOC;
        req_ch.job_id     = '0;
        req_ch.page_count = '0;
        rsp_ch.ready      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct  = 27;
        rx_idle_pct <= 73;
        @(negedge i_clk);

        send_request(KIND_ALLOC, 4'd0, 7'd64);
        send_request(KIND_ALLOC, 4'd0, 7'd1);
        send_request(KIND_ALLOC, 4'd1, 7'd0);
        send_request(KIND_RELEASE, 4'd1, 7'd0);
        send_request(KIND_ALLOC, 4'd1, 7'd65);
        send_request(KIND_ALLOC, 4'd2, 7'd127);
        send_request(KIND_ALLOC, 4'd15, 7'd1);
        send_request(KIND_ALLOC, 4'd2, 7'd3);
        send_request(KIND_RELEASE, 4'd0, 7'd127);
        send_request(KIND_ALLOC, 4'd3, 7'd5);
        send_request(KIND_RELEASE, 4'd15, 7'd0);
        send_request(KIND_ALLOC, 4'd4, 7'd64);
        send_request(KIND_RELEASE, 4'd2, 7'd64);
        send_request(KIND_RELEASE, 4'd3, 7'd1);
        send_request(KIND_RELEASE, 4'd4, 7'd0);
        wait_for_results();

        write_block_count(11'd1);
        send_request(KIND_ALLOC, 4'd7, 7'd1);
        send_request(KIND_ALLOC, 4'd8, 7'd1);
        send_request(KIND_RELEASE, 4'd7, 7'd0);
        send_request(KIND_ALLOC, 4'd9, 7'd2);
        send_request(KIND_ALLOC, 4'd10, 7'd1);
        send_request(KIND_RELEASE, 4'd10, 7'd0);
        wait_for_results();

        write_block_count(11'd1023);
        run_random(70);
        wait_for_results();

        tx_idle_pct  = 73;
        rx_idle_pct <= 27;
        write_block_count(11'd200);
        run_random(70);
        wait_for_results();

        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        write_block_count(11'd1024);
        hold_trigger <= hold_trigger + 1;
        run_random(12);
        wait_for_results();
        write_block_count(11'd70);
        run_random(37);
        wait_for_results();

        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
